[hw/rtl/tirm_pkg.sv]
package tirm_pkg;

  // Field widths of the pixel streams and the configuration port.
  localparam int COL_W      = 11;
  localparam int COLOUR_W   = 32;
  localparam int ANGLE_W    = 9;
  localparam int DIM_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Reset values of the frame size registers.
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_X     = 3'd0,
    CFG_ANGLE_Y     = 3'd1,
    CFG_ANGLE_Z     = 3'd2,
    CFG_SRC_WIDTH   = 3'd3,
    CFG_SRC_HEIGHT  = 3'd4,
    CFG_DEST_WIDTH  = 3'd5,
    CFG_DEST_HEIGHT = 3'd6
  } cfg_reg_t;

  // Quarter-wave sine table, round(16384 * sin(k degrees)) for k = 0..90.
  localparam int TABLE_FRAC = 14;
  localparam int SINE_W     = 15;
  localparam int SINE_DEPTH = 91;

  localparam logic [SINE_W-1:0] QUARTER_SINE [SINE_DEPTH] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
    15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
    15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
    15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
    15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
    15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
    15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
    15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
    15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
    15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
    15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
    15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
    15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

endpackage

[hw/rtl/tirm_pix_if.sv]
// Source pixel stream.
interface tirm_pix_in_if;
  logic                             valid;
  logic                             ready;
  logic [tirm_pkg::COL_W-1:0]       src_col;
  logic [tirm_pkg::COL_W-1:0]       src_row;
  logic [tirm_pkg::COLOUR_W-1:0]    pixel_colour;

  modport source (output valid, output src_col, output src_row, output pixel_colour,
                  input ready);
  modport sink (input valid, input src_col, input src_row, input pixel_colour,
                output ready);
endinterface

// Destination pixel stream.
interface tirm_pix_out_if;
  logic                             valid;
  logic                             ready;
  logic [tirm_pkg::COL_W-1:0]       dst_col;
  logic [tirm_pkg::COL_W-1:0]       dst_row;
  logic [tirm_pkg::COLOUR_W-1:0]    out_colour;

  modport source (output valid, output dst_col, output dst_row, output out_colour,
                  input ready);
  modport sink (input valid, input dst_col, input dst_row, input out_colour,
                output ready);
endinterface

[hw/rtl/three_axis_image_rotation_mapper.sv]
// Three-axis image rotation mapper, forward mapped with an orthographic view.
//
// Source pixels arrive on pix_in as one beat each: column, row and colour.
// Each pixel is rotated about the source image centre by Rx*Ry*Rz, depth is
// dropped, and the position is re-centred in the destination frame. When the
// floor of that position lies inside the destination frame, one beat leaves
// on pix_out with the destination column, row and the unchanged colour;
// otherwise the pixel produces no beat at all.
//
// Throughput is one pixel per clock unless pix_out stalls or a config
// write or settle period holds pix_in.ready low. A result passes the
// three pixel registers: input, products, result. When pix_out stalls,
// the path holds and pix_in.ready drops in the same cycle; nothing is lost.
//
// The configuration port writes one register per cycle on cfg_write. An
// angle write restarts the coefficient pipeline (trig lookup, two rounds of
// products, final sums), and pix_in.ready stays low from the write cycle
// until the settle counter has run down. Reset is synchronous; it loads the
// default angles and frame sizes and holds pix_in.ready low while the
// identity coefficients settle.
module three_axis_image_rotation_mapper #(
  parameter int MAX_DIM        = 2048,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  tirm_pix_in_if.sink                          pix_in,
  tirm_pix_out_if.source                       pix_out,
  input  logic                                 cfg_write,
  input  logic [tirm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tirm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tirm_pkg::*;

  // Frame sizes are clamped to MAX_DIM; DW is wide enough for the clamped value.
  localparam int DW = ($clog2(MAX_DIM + 1) < DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
  // Trig values, coefficients, pixel offsets and positions.
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int CW = TRIG_FRAC_BITS + 3;
  localparam int DXW = COL_W + 2;
  localparam int PW = CW + DXW;
  // Integer part of a position, which is in units of half a pixel divided by 2^F.
  localparam int QW = PW - TRIG_FRAC_BITS - 2;
  localparam logic signed [2*CW-1:0] QHALF = (2*CW)'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic [1:0] SETTLE = 2'd3;

  // Product of two Q3.F values, rounded half up to F fraction bits.
  function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    logic signed [2*CW-1:0] s;
    p = (2*CW)'(a) * (2*CW)'(b) + QHALF;
    s = p >>> TRIG_FRAC_BITS;
    return s[CW-1:0];
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (32'(v) > 32'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return DW'(v);
  endfunction

  // Configuration registers.
  logic [ANGLE_W-1:0] angle_x;
  logic [ANGLE_W-1:0] angle_y;
  logic [ANGLE_W-1:0] angle_z;
  logic [DIM_W-1:0]   src_width;
  logic [DIM_W-1:0]   src_height;
  logic [DIM_W-1:0]   dest_width;
  logic [DIM_W-1:0]   dest_height;
  logic               angle_write;

  always_comb begin
    angle_write = cfg_write && (cfg_index == CFG_ANGLE_X || cfg_index == CFG_ANGLE_Y ||
                                cfg_index == CFG_ANGLE_Z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x     <= '0;
      angle_y     <= '0;
      angle_z     <= '0;
      src_width   <= RESET_WIDTH;
      src_height  <= RESET_HEIGHT;
      dest_width  <= RESET_WIDTH;
      dest_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ANGLE_X:     angle_x     <= cfg_data[ANGLE_W-1:0];
        CFG_ANGLE_Y:     angle_y     <= cfg_data[ANGLE_W-1:0];
        CFG_ANGLE_Z:     angle_z     <= cfg_data[ANGLE_W-1:0];
        CFG_SRC_WIDTH:   src_width   <= cfg_data;
        CFG_SRC_HEIGHT:  src_height  <= cfg_data;
        CFG_DEST_WIDTH:  dest_width  <= cfg_data;
        CFG_DEST_HEIGHT: dest_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficient pipeline. It runs freely from the angle registers: trig stage,
  // two product rounds, final sums. The settle counter keeps pixels out
  // until the coefficients follow the latest angles.
  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

  tirm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_x (
    .clk(clk), .angle(angle_x), .sine(sx), .cosine(cx)
  );
  tirm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_y (
    .clk(clk), .angle(angle_y), .sine(sy), .cosine(cy)
  );
  tirm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_z (
    .clk(clk), .angle(angle_z), .sine(sz), .cosine(cz)
  );

  logic signed [CW-1:0] sx_e, cx_e, sy_e, cy_e, sz_e, cz_e;

  always_comb begin
    sx_e = CW'(sx);
    cx_e = CW'(cx);
    sy_e = CW'(sy);
    cy_e = CW'(cy);
    sz_e = CW'(sz);
    cz_e = CW'(cz);
  end

  // First round: everything that needs only the trig values.
  logic signed [CW-1:0] p1_sxsy, p1_cycz, p1_cysz, p1_cxsz, p1_cxcz, p1_cz, p1_sz;
  // Second round: the products that take sin(x)*sin(y), and the first-round products carried along.
  logic signed [CW-1:0] p2_sxsycz, p2_sxsysz, p2_cycz, p2_cysz, p2_cxsz, p2_cxcz;
  // Rotation coefficients r00, r01, r10, r11.
  logic signed [CW-1:0] r00, r01, r10, r11;

  always_ff @(posedge clk) begin
    p1_sxsy   <= qmul(sx_e, sy_e);
    p1_cycz   <= qmul(cy_e, cz_e);
    p1_cysz   <= qmul(cy_e, sz_e);
    p1_cxsz   <= qmul(cx_e, sz_e);
    p1_cxcz   <= qmul(cx_e, cz_e);
    p1_cz     <= cz_e;
    p1_sz     <= sz_e;

    p2_sxsycz <= qmul(p1_sxsy, p1_cz);
    p2_sxsysz <= qmul(p1_sxsy, p1_sz);
    p2_cycz   <= p1_cycz;
    p2_cysz   <= p1_cysz;
    p2_cxsz   <= p1_cxsz;
    p2_cxcz   <= p1_cxcz;

    r00       <= p2_cycz;
    r01       <= -p2_cysz;
    r10       <= p2_sxsycz + p2_cxsz;
    r11       <= p2_cxcz - p2_sxsysz;
  end

  logic [1:0] settle;
  logic [1:0] settle_next;

  always_comb begin
    priority if (angle_write) begin
      settle_next = SETTLE;
    end else if (settle != 2'd0) begin
      settle_next = settle - 2'd1;
    end else begin
      settle_next = settle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE;
    end else begin
      settle <= settle_next;
    end
  end

  // Frame geometry, registered from the size registers. base_x and base_y
  // hold the source centre plus the destination offset in position units.
  logic [DW-1:0]          w_c, h_c, nw_c, nh_c;
  logic signed [DW:0]     off_x, off_y;
  logic signed [PW-1:0]   base_x, base_y;

  always_comb begin
    off_x = $signed({2'b00, nw_c[DW-1:1]}) - $signed({2'b00, w_c[DW-1:1]});
    off_y = $signed({2'b00, nh_c[DW-1:1]}) - $signed({2'b00, h_c[DW-1:1]});
  end

  always_ff @(posedge clk) begin
    w_c    <= clamp_dim(src_width);
    h_c    <= clamp_dim(src_height);
    nw_c   <= clamp_dim(dest_width);
    nh_c   <= clamp_dim(dest_height);
    base_x <= (PW'(w_c) << TRIG_FRAC_BITS) + (PW'(off_x) <<< (TRIG_FRAC_BITS + 1));
    base_y <= (PW'(h_c) << TRIG_FRAC_BITS) + (PW'(off_y) <<< (TRIG_FRAC_BITS + 1));
  end

  // Pixel path: input register, product register, result register. All
  // three advance together whenever the result register is free.
  logic                   advance;
  logic                   s1_valid;
  logic [COL_W-1:0]       s1_col, s1_row;
  logic [COLOUR_W-1:0]    s1_colour;
  logic                   s2_valid;
  logic signed [PW-1:0]   s2_m00, s2_m01, s2_m10, s2_m11;
  logic [COLOUR_W-1:0]    s2_colour;
  logic                   out_valid;
  logic [COL_W-1:0]       out_col, out_row;
  logic [COLOUR_W-1:0]    out_colour_q;

  always_comb begin
    advance      = !out_valid || pix_out.ready;
    pix_in.ready = advance && (settle == 2'd0) && !cfg_write;
  end

  // Offsets from the centre, in half pixels: 2*i - w.
  logic signed [DXW-1:0] dx, dy;

  always_comb begin
    dx = $signed({1'b0, s1_col, 1'b0} - DXW'(w_c));
    dy = $signed({1'b0, s1_row, 1'b0} - DXW'(h_c));
  end

  // Rotated position and the destination bounds test.
  logic signed [PW-1:0] pos_x, pos_y;
  logic [QW-1:0]        col_q, row_q;
  logic                 hit;

  always_comb begin
    pos_x = s2_m00 + s2_m01 + base_x;
    pos_y = s2_m10 + s2_m11 + base_y;
    col_q = pos_x[PW-2:TRIG_FRAC_BITS+1];
    row_q = pos_y[PW-2:TRIG_FRAC_BITS+1];
    hit   = !pos_x[PW-1] && !pos_y[PW-1] && (col_q < QW'(nw_c)) && (row_q < QW'(nh_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pix_in.valid && pix_in.ready;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col       <= pix_in.src_col;
      s1_row       <= pix_in.src_row;
      s1_colour    <= pix_in.pixel_colour;
      s2_m00       <= PW'(r00) * PW'(dx);
      s2_m01       <= PW'(r01) * PW'(dy);
      s2_m10       <= PW'(r10) * PW'(dx);
      s2_m11       <= PW'(r11) * PW'(dy);
      s2_colour    <= s1_colour;
      out_col      <= col_q[COL_W-1:0];
      out_row      <= row_q[COL_W-1:0];
      out_colour_q <= s2_colour;
    end
  end

  always_comb begin
    pix_out.valid      = out_valid;
    pix_out.dst_col    = out_col;
    pix_out.dst_row    = out_row;
    pix_out.out_colour = out_colour_q;
  end

endmodule

[hw/rtl/tirm_trig.sv]
// Registered sine and cosine of a whole-degree angle, signed Q2.TRIG_FRAC_BITS.
module tirm_trig #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic [tirm_pkg::ANGLE_W-1:0]        angle,
  output logic signed [TRIG_FRAC_BITS+1:0]    sine,
  output logic signed [TRIG_FRAC_BITS+1:0]    cosine
);
  import tirm_pkg::*;

  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int SL  = (TRIG_FRAC_BITS >= TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
  localparam int SR  = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
  localparam logic [31:0] RND = (SR > 0) ? (32'd1 << (SR - 1)) : 32'd0;

  // Bring a table entry from Q14 to the working fraction width, rounding half up.
  function automatic logic signed [TW-1:0] rescale(input logic [SINE_W-1:0] v);
    logic [31:0] t;
    t = 32'(v) << SL;
    t = (t + RND) >> SR;
    return t[TW-1:0];
  endfunction

  // Sine of an angle below 720 degrees.
  function automatic logic signed [TW-1:0] sin_deg(input logic [9:0] deg);
    logic [9:0]              d;
    logic [6:0]              r;
    logic [6:0]              idx;
    logic                    neg;
    logic                    mirror;
    logic signed [TW-1:0]    mag;
    d      = (deg >= 10'd360) ? deg - 10'd360 : deg;
    neg    = 1'b0;
    mirror = 1'b0;
    priority if (d >= 10'd270) begin
      r      = 7'(d - 10'd270);
      neg    = 1'b1;
      mirror = 1'b1;
    end else if (d >= 10'd180) begin
      r   = 7'(d - 10'd180);
      neg = 1'b1;
    end else if (d >= 10'd90) begin
      r      = 7'(d - 10'd90);
      mirror = 1'b1;
    end else begin
      r = d[6:0];
    end
    idx = mirror ? 7'd90 - r : r;
    mag = rescale(QUARTER_SINE[idx]);
    return neg ? -mag : mag;
  endfunction

  logic [9:0] angle_mod;

  always_comb begin
    angle_mod = (angle >= 9'd360) ? 10'(angle - 9'd360) : 10'(angle);
  end

  always_ff @(posedge clk) begin
    sine   <= sin_deg(angle_mod);
    cosine <= sin_deg(angle_mod + 10'd90);
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import tirm_pkg::*;

  localparam int MAX_SIZE      = 2048;
  localparam int FRAC          = 14;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PIXELS = 1800;
  localparam int PRINT_CAP     = 60;

  // Index 7 decodes to no register; writes there must leave the block alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int unsigned CORNER_ANGLES [7] = '{0, 90, 180, 270, 359, 360, 511};
  localparam int unsigned CORNER_SIZES [4]  = '{1, 2, 2048, 4095};

  // One pixel beat, used for both the source and the destination stream.
  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [COL_W-1:0]    row;
    logic [COLOUR_W-1:0] colour;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tirm_pix_in_if  pix_in ();
  tirm_pix_out_if pix_out ();

  three_axis_image_rotation_mapper #(
    .MAX_DIM        (MAX_SIZE),
    .TRIG_FRAC_BITS (FRAC)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the configuration registers and the rotation coefficients.
  // The coefficients are signed fixed point with FRAC fraction bits.
  logic [ANGLE_W-1:0] angle_x, angle_y, angle_z;
  logic [DIM_W-1:0]   src_w, src_h, dst_w, dst_h;
  longint             coef [4];

  pixel_t src_q [$];       // source beats waiting for the driver
  pixel_t batch_q [$];     // beats being assembled for the next phase
  pixel_t expected_q [$];  // destination beats still owed by the block

  int errors       = 0;
  int cycle_count  = 0;
  int beats_taken  = 0;
  int beats_queued = 0;
  bit in_taken     = 1'b0;

  // Pacing controls. The pace flags and the hold request are set only at a
  // rising edge, while the driver and the receiver act on falling edges.
  bit tx_pace      = 1'b0;
  bit rx_pace      = 1'b0;
  bit hold_request = 1'b0;
  int burst_left   = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;

  // Sine of a whole-degree angle, built from the quarter-wave table and
  // rescaled to FRAC fraction bits with rounding half up.
  function automatic longint sine_q(int unsigned deg);
    int unsigned d;
    int unsigned r;
    longint      mag;
    d = deg % 360;
    r = d % 90;
    if (((d / 90) % 2) == 0) begin
      mag = longint'(QUARTER_SINE[r]);
    end else begin
      mag = longint'(QUARTER_SINE[90 - r]);
    end
    if (FRAC >= TABLE_FRAC) begin
      mag = mag <<< (FRAC - TABLE_FRAC);
    end else begin
      mag = (mag + (longint'(1) <<< (TABLE_FRAC - FRAC - 1))) >>> (TABLE_FRAC - FRAC);
    end
    return (d >= 180) ? -mag : mag;
  endfunction

  function automatic longint cosine_q(int unsigned deg);
    return sine_q((deg % 360) + 90);
  endfunction

  // Fixed-point product, rounded half toward plus infinity.
  function automatic longint qmul(longint a, longint b);
    return (a * b + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // Collapses Rx*Ry*Rz to the four terms that survive the orthographic view.
  function automatic void rebuild_rotation();
    longint sx, cx, sy, cy, sz, cz, sxsy;
    sx   = sine_q(angle_x);
    cx   = cosine_q(angle_x);
    sy   = sine_q(angle_y);
    cy   = cosine_q(angle_y);
    sz   = sine_q(angle_z);
    cz   = cosine_q(angle_z);
    sxsy = qmul(sx, sy);
    coef[0] = qmul(cy, cz);
    coef[1] = -qmul(cy, sz);
    coef[2] = qmul(sxsy, cz) + qmul(cx, sz);
    coef[3] = qmul(cx, cz) - qmul(sxsy, sz);
  endfunction

  function automatic longint limit_size(logic [DIM_W-1:0] v);
    return (v > MAX_SIZE) ? longint'(MAX_SIZE) : longint'(v);
  endfunction

  // Forward maps one source pixel. Positions are carried in units of
  // 2^-(FRAC+1) pixel, since the centre offsets are whole pixels times two.
  // Returns 1 when the pixel lands inside the destination frame.
  function automatic bit map_source_pixel(pixel_t src, output pixel_t dst);
    longint w, h, nw, nh, dx, dy, offx, offy, px, py, col, row;
    w    = limit_size(src_w);
    h    = limit_size(src_h);
    nw   = limit_size(dst_w);
    nh   = limit_size(dst_h);
    dx   = 2 * longint'(src.col) - w;
    dy   = 2 * longint'(src.row) - h;
    offx = nw / 2 - w / 2;
    offy = nh / 2 - h / 2;
    px   = coef[0] * dx + coef[1] * dy + (w <<< FRAC) + (offx <<< (FRAC + 1));
    py   = coef[2] * dx + coef[3] * dy + (h <<< FRAC) + (offy <<< (FRAC + 1));
    dst  = '0;
    if (px < 0 || py < 0) begin
      return 1'b0;
    end
    col = px >>> (FRAC + 1);
    row = py >>> (FRAC + 1);
    if (col >= nw || row >= nh) begin
      return 1'b0;
    end
    dst.col    = col[COL_W-1:0];
    dst.row    = row[COL_W-1:0];
    dst.colour = src.colour;
    return 1'b1;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // Run limit. A hung handshake or a missing beat ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("three_axis_image_rotation_mapper regression: fail");
      $finish;
    end
  end

  // Monitor. Everything is sampled on the rising edge: register writes
  // update the mirror, destination beats are checked against the oldest
  // expectation, and each accepted source beat is mapped right away.
  always @(posedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    pixel_t mapped;
    if (rst) begin
      angle_x  = '0;
      angle_y  = '0;
      angle_z  = '0;
      src_w    = RESET_WIDTH;
      src_h    = RESET_HEIGHT;
      dst_w    = RESET_WIDTH;
      dst_h    = RESET_HEIGHT;
      coef[0]  = longint'(1) <<< FRAC;
      coef[1]  = 0;
      coef[2]  = 0;
      coef[3]  = longint'(1) <<< FRAC;
      in_taken = 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ANGLE_X: begin
            angle_x = cfg_data[ANGLE_W-1:0];
            rebuild_rotation();
          end
          CFG_ANGLE_Y: begin
            angle_y = cfg_data[ANGLE_W-1:0];
            rebuild_rotation();
          end
          CFG_ANGLE_Z: begin
            angle_z = cfg_data[ANGLE_W-1:0];
            rebuild_rotation();
          end
          CFG_SRC_WIDTH:   src_w = cfg_data;
          CFG_SRC_HEIGHT:  src_h = cfg_data;
          CFG_DEST_WIDTH:  dst_w = cfg_data;
          CFG_DEST_HEIGHT: dst_h = cfg_data;
          default: ;
        endcase
      end

      if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
        got = {pix_out.dst_col, pix_out.dst_row, pix_out.out_colour};
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected beat col %0d row %0d colour %h",
                           got.col, got.row, got.colour));
        end else begin
          want = expected_q.pop_front();
          if (got.col !== want.col) begin
            report($sformatf("dst_col %0d, expected %0d", got.col, want.col));
          end
          if (got.row !== want.row) begin
            report($sformatf("dst_row %0d, expected %0d", got.row, want.row));
          end
          if (got.colour !== want.colour) begin
            report($sformatf("out_colour %h, expected %h", got.colour, want.colour));
          end
        end
      end

      in_taken = (pix_in.valid === 1'b1 && pix_in.ready === 1'b1);
      if (in_taken) begin
        beats_taken++;
        if (map_source_pixel({pix_in.src_col, pix_in.src_row, pix_in.pixel_colour},
                             mapped)) begin
          expected_q.push_back(mapped);
        end
      end
    end
  end

  // Source driver. A beat is held until the monitor saw it accepted. With
  // pacing on, beats go out in bursts of random length with random gaps.
  always @(negedge clk) begin : driver
    pixel_t item;
    if (!pix_in.valid || in_taken) begin
      if (tx_pace && gap_left > 0) begin
        gap_left--;
        pix_in.valid <= 1'b0;
      end else if (src_q.size() == 0) begin
        pix_in.valid <= 1'b0;
      end else begin
        item = src_q.pop_front();
        pix_in.valid        <= 1'b1;
        pix_in.src_col      <= item.col;
        pix_in.src_row      <= item.row;
        pix_in.pixel_colour <= item.colour;
        if (tx_pace) begin
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = $urandom_range(0, 10);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Long hold-off of the receiver, counted here so the stimulus can carry on
  // offering beats while the block backs up and drops its input ready.
  always @(negedge clk) begin : hold_off
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
      hold_request = 1'b0;
    end
  end

  // Receiver. With pacing on it stalls at random.
  always @(negedge clk) begin : receiver
    if (hold_left > 0) begin
      pix_out.ready <= 1'b0;
    end else if (!rx_pace) begin
      pix_out.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_pixel(int unsigned col, int unsigned row, logic [COLOUR_W-1:0] colour);
    pixel_t item;
    item.col    = col[COL_W-1:0];
    item.row    = row[COL_W-1:0];
    item.colour = colour;
    batch_q.push_back(item);
  endtask

  // Hands the assembled phase to the driver on a rising edge, with its pacing.
  task automatic start_batch(bit tx, bit rx, bit hold);
    @(posedge clk);
    tx_pace      = tx;
    rx_pace      = rx;
    hold_request = hold;
    beats_queued += batch_q.size();
    foreach (batch_q[i]) begin
      src_q.push_back(batch_q[i]);
    end
    batch_q.delete();
  endtask

  // Waits until every source beat is in and every owed beat is out. A pixel
  // that maps outside the frame leaves no trace, so the task then waits with
  // the receiver ready to flush the pixel path before registers change.
  task automatic drain();
    int ready_cycles = 0;
    do begin
      @(negedge clk);
    end while (beats_taken != beats_queued || expected_q.size() != 0);
    while (ready_cycles < 6) begin
      @(negedge clk);
      if (pix_out.ready === 1'b1) begin
        ready_cycles++;
      end
    end
  endtask

  function automatic int unsigned pick_angle(bit corner);
    if (corner) begin
      return CORNER_ANGLES[$urandom_range(0, 6)];
    end
    // Now and then use the whole data word; the upper bits must not matter.
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 4095);
    end
    return $urandom_range(0, 359);
  endfunction

  function automatic int unsigned pick_size(bit corner);
    if (corner) begin
      return CORNER_SIZES[$urandom_range(0, 3)];
    end
    case ($urandom_range(0, 19))
      0:          return 0;
      1, 2:       return $urandom_range(2049, 4095);
      3, 4, 5, 6: return $urandom_range(1, 16);
      default:    return $urandom_range(1, 2048);
    endcase
  endfunction

  // Writes a random subset of the registers; corner phases write them all
  // from the list of extreme values.
  task automatic configure_random(bit corner);
    cfg_reg_t sel;
    sel = sel.first();
    repeat (sel.num()) begin
      if (corner || $urandom_range(0, 3) != 0) begin
        if (sel == CFG_ANGLE_X || sel == CFG_ANGLE_Y || sel == CFG_ANGLE_Z) begin
          write_reg(sel, pick_angle(corner));
        end else begin
          write_reg(sel, pick_size(corner));
        end
      end
      sel = sel.next();
    end
    if ($urandom_range(0, 5) == 0) begin
      write_reg(CFG_UNUSED, $urandom_range(0, 4095));
    end
  endtask

  initial begin : stimulus
    int     total;
    int     phase;
    int     count;
    longint w;
    longint h;
    int unsigned col;
    int unsigned row;

    pix_in.valid        = 1'b0;
    pix_in.src_col      = '0;
    pix_in.src_row      = '0;
    pix_in.pixel_colour = '0;
    pix_out.ready       = 1'b0;
    cfg_write           = 1'b0;
    cfg_index           = CFG_ANGLE_X;
    cfg_data            = '0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: identity rotation, 640 by 480 on both sides. Corners
    // of the frame, the first column and row past it, and the far end of
    // the field ranges.
    add_pixel(0, 0, 32'h0000_0000);
    add_pixel(639, 479, 32'hFFFF_FFFF);
    add_pixel(640, 0, $urandom());
    add_pixel(0, 480, $urandom());
    add_pixel(2047, 2047, $urandom());
    add_pixel(320, 240, 32'hA5A5_5A5A);
    start_batch(1'b0, 1'b0, 1'b0);
    drain();

    // A write to the unused index must change nothing; then a quarter turn
    // about the viewing axis.
    write_reg(CFG_UNUSED, 4095);
    write_reg(CFG_ANGLE_Z, 90);
    add_pixel(0, 0, 32'hFFFF_FFFF);
    add_pixel(639, 479, $urandom());
    add_pixel(100, 50, $urandom());
    start_batch(1'b0, 1'b0, 1'b0);
    drain();

    // Angles of a full turn or more wrap around.
    write_reg(CFG_ANGLE_X, 400);
    write_reg(CFG_ANGLE_Y, 359);
    write_reg(CFG_ANGLE_Z, 450);
    add_pixel(0, 0, $urandom());
    add_pixel(639, 479, $urandom());
    add_pixel(320, 240, $urandom());
    start_batch(1'b1, 1'b1, 1'b0);
    drain();

    // A size beyond the limit is clamped, a zero source size centres on
    // zero, and a zero destination size never lets a pixel through.
    write_reg(CFG_ANGLE_X, 0);
    write_reg(CFG_ANGLE_Y, 0);
    write_reg(CFG_ANGLE_Z, 0);
    write_reg(CFG_SRC_WIDTH, 4095);
    write_reg(CFG_SRC_HEIGHT, 0);
    write_reg(CFG_DEST_WIDTH, 2048);
    write_reg(CFG_DEST_HEIGHT, 0);
    add_pixel(0, 0, $urandom());
    add_pixel(1024, 0, $urandom());
    add_pixel(2047, 2047, $urandom());
    start_batch(1'b0, 1'b0, 1'b0);
    drain();

    write_reg(CFG_DEST_HEIGHT, 4095);
    write_reg(CFG_SRC_HEIGHT, 1);
    write_reg(CFG_ANGLE_Y, 180);
    write_reg(CFG_ANGLE_Z, 270);
    add_pixel(0, 0, $urandom());
    add_pixel(2047, 2047, $urandom());
    add_pixel(1024, 0, $urandom());
    start_batch(1'b0, 1'b0, 1'b0);
    drain();

    // Largest frames on both sides, half a turn about every axis.
    write_reg(CFG_ANGLE_X, 180);
    write_reg(CFG_ANGLE_Y, 180);
    write_reg(CFG_ANGLE_Z, 180);
    write_reg(CFG_SRC_WIDTH, 2048);
    write_reg(CFG_SRC_HEIGHT, 2048);
    write_reg(CFG_DEST_WIDTH, 2048);
    write_reg(CFG_DEST_HEIGHT, 2048);
    add_pixel(0, 0, $urandom());
    add_pixel(2047, 2047, $urandom());
    add_pixel(1023, 1024, $urandom());
    start_batch(1'b0, 1'b0, 1'b0);
    drain();

    // Random phases. Each one changes some registers, then streams pixels
    // that mostly fall inside the source image. Every fourth phase uses
    // only extreme settings, every third runs without idling on either
    // side, and one phase carries the long receiver hold-off.
    total = 0;
    phase = 0;
    while (total < RANDOM_PIXELS) begin
      configure_random(phase % 4 == 3);
      w = limit_size(src_w);
      h = limit_size(src_h);
      count = $urandom_range(60, 200);
      repeat (count) begin
        if (w > 0 && $urandom_range(0, 4) != 0) begin
          col = $urandom_range(0, 32'(w - 1));
        end else begin
          col = $urandom_range(0, 2047);
        end
        if (h > 0 && $urandom_range(0, 4) != 0) begin
          row = $urandom_range(0, 32'(h - 1));
        end else begin
          row = $urandom_range(0, 2047);
        end
        add_pixel(col, row, $urandom());
      end
      if (phase == 2) begin
        start_batch(1'b0, 1'b0, 1'b1);
      end else if (phase % 3 == 0) begin
        start_batch(1'b0, 1'b0, 1'b0);
      end else begin
        start_batch(1'b1, 1'b1, 1'b0);
      end
      drain();
      total += count;
      phase++;
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("three_axis_image_rotation_mapper regression: pass");
    end else begin
      $display("three_axis_image_rotation_mapper regression: fail");
    end
    $finish;
  end

endmodule
